// ===== rtl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and codes for the LRU page replacement list.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCESS = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_EVICT  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_ADDED   = 3'd1,
    ST_EVICTED = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic promote;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lrupr_req_if.sv =====
// ----------------------------------------------------------------------------
// lrupr_req_if
// Request channel: one list operation per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrupr_req_if
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output kind, output page_number, input ready);
  modport sink   (input valid, input kind, input page_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrupr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lrupr_rsp_if
// Response channel: status and victim page of one operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrupr_rsp_if
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [PAGE_BITS-1:0] victim_page;

  modport source (output valid, output status, output victim_page, input ready);
  modport sink   (input valid, input status, input victim_page, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell
// One recency slot: holds a page, compares it to the key, shifts from its
// younger neighbor on promote and offers its page when it is the oldest.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = 20,
  parameter int CNT_W     = 5,
  parameter int INDEX     = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic [PAGE_BITS-1:0] key,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic [PAGE_BITS-1:0] prev_page,
  input  wire logic                 seen_in,
  output logic                      seen_out,
  input  wire logic [PAGE_BITS-1:0] victim_in,
  output logic [PAGE_BITS-1:0]      victim_out,
  output logic [PAGE_BITS-1:0]      page
);

  logic match;
  logic occupied;
  logic oldest;

  assign occupied   = CNT_W'(INDEX) < count;
  assign oldest     = CNT_W'(INDEX + 1) == count;
  assign seen_out   = seen_in | match;
  assign victim_out = victim_in | (oldest ? page : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.capture) begin
      match <= occupied && (page == key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.promote && !seen_in) begin
      page <= prev_page;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement_list_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_list_top
// LRU page list built as a row of shifting cells, most recent at cell zero.
// ----------------------------------------------------------------------------
// the request is registered on transfer; response valid is registered when the request executes
// one request at a time, none taken while busy; compare on transfer, then shift once the response slot is free
// the hit flag and victim page ripple cell to cell across the row
// reset: list empty, response channel idle; page slots hold no reset value
`default_nettype none

module lru_page_replacement_list_top
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 20
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lrupr_req_if.sink   req,
  lrupr_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(FRAMES + 1);

  logic                 busy;
  logic                 op_evict;
  logic [PAGE_BITS-1:0] key;
  logic [CNT_W-1:0]     count;
  logic                 accept;
  logic                 exec;
  logic                 hit;
  logic                 full;
  cell_ctrl_t           ctrl;

  logic [FRAMES:0]                  seen;
  logic [FRAMES:0][PAGE_BITS-1:0]   victim;
  logic [FRAMES-1:0][PAGE_BITS-1:0] page;

  assign req.ready = !busy;
  assign accept    = req.valid && !busy;
  assign exec      = busy && (!rsp.valid || rsp.ready);
  assign hit       = seen[FRAMES];
  assign full      = count == CNT_W'(FRAMES);

  assign ctrl.capture = accept;
  assign ctrl.promote = exec && !op_evict && (hit || !full);

  assign seen[0]   = 1'b0;
  assign victim[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] prev_page;
    if (i == 0) begin : g_head
      assign prev_page = key;
    end else begin : g_body
      assign prev_page = page[i-1];
    end
    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (req.page_number),
      .count      (count),
      .prev_page  (prev_page),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .victim_in  (victim[i]),
      .victim_out (victim[i+1]),
      .page       (page[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= req.page_number;
      op_evict <= req.kind[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (exec) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
        if (op_evict) begin
          if (count != '0) begin
            count <= count - CNT_W'(1);
          end
        end else if (!hit && !full) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp.victim_page <= '0;
      if (op_evict) begin
        if (count == '0) begin
          rsp.status <= ST_EMPTY;
        end else begin
          rsp.status      <= ST_EVICTED;
          rsp.victim_page <= victim[FRAMES];
        end
      end else if (hit) begin
        rsp.status <= ST_HIT;
      end else if (full) begin
        rsp.status <= ST_FULL;
      end else begin
        rsp.status <= ST_ADDED;
      end
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FRAMES))
    else $error("resident count above frame count");

  a_exec_response: assert property (@(posedge clk) disable iff (rst)
    exec |=> rsp.valid && !busy)
    else $error("executed request gave no response");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    exec && !op_evict && !hit && full |=> rsp.status == ST_FULL && $stable(count))
    else $error("full list changed on refused page");

  a_empty_evict: assert property (@(posedge clk) disable iff (rst)
    exec && op_evict && count == '0 |=> rsp.victim_page == '0 && count == '0)
    else $error("evict on empty list changed state");
`endif

endmodule

`default_nettype wire
